### src/u8250_pkg.sv
// ----------------------------------------------------------------------------
// u8250_pkg
// Types and constants shared by the 8250-style UART register block.
// ----------------------------------------------------------------------------
`default_nettype none

package u8250_pkg;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_RX    = 2'd2,
    KIND_NOP   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    FAULT_NONE      = 2'd0,
    FAULT_LOAD_MIS  = 2'd1,
    FAULT_STORE_MIS = 2'd2,
    FAULT_ILLEGAL   = 2'd3
  } fault_e;

  typedef enum logic [2:0] {
    SIZE_BYTE_U = 3'd0,
    SIZE_BYTE_S = 3'd1,
    SIZE_HALF   = 3'd2,
    SIZE_WORD   = 3'd3
  } size_e;

  // register offsets
  localparam logic [2:0] ADDR_RBR = 3'd0;
  localparam logic [2:0] ADDR_IER = 3'd1;
  localparam logic [2:0] ADDR_IIR = 3'd2;
  localparam logic [2:0] ADDR_LCR = 3'd3;
  localparam logic [2:0] ADDR_MCR = 3'd4;
  localparam logic [2:0] ADDR_LSR = 3'd5;
  localparam logic [2:0] ADDR_MSR = 3'd6;

  localparam int unsigned DLAB_BIT  = 7;
  localparam int unsigned SRC_THRE  = 1;
  localparam logic [7:0]  LSR_FIXED = 8'h60;
  localparam logic [7:0]  MSR_FIXED = 8'hB0;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] reg_addr;
    logic [2:0] access_size;
    logic [7:0] write_data;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  fault;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq;
  } out_t;

endpackage

`default_nettype wire

### src/u8250_core.sv
// ----------------------------------------------------------------------------
// u8250_core
// Register file state and per-beat decode: bus read/write, receive event and
// the interrupt update. State advances on step_i; result_o is combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module u8250_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  u8250_pkg::in_t   item_i,
  output u8250_pkg::out_t  result_o
);
  import u8250_pkg::*;

  logic [7:0] lcr_q, lcr_d;
  logic [7:0] ier_q, ier_d;
  logic [7:0] mcr_q, mcr_d;
  logic [7:0] dll_q, dll_d;
  logic [7:0] dlh_q, dlh_d;
  logic [1:0] pend_q, pend_d;
  logic       cur_q, cur_d;
  logic       rx_rdy_q, rx_rdy_d;
  logic [7:0] rx_hold_q, rx_hold_d;

  logic       dlab;
  logic [7:0] rbyte;
  logic [1:0] pend_w;
  logic       do_read;
  logic       do_write;

  assign dlab = lcr_q[DLAB_BIT];

  always_comb begin
    lcr_d     = lcr_q;
    ier_d     = ier_q;
    mcr_d     = mcr_q;
    dll_d     = dll_q;
    dlh_d     = dlh_q;
    pend_w    = pend_q;
    cur_d     = cur_q;
    rx_rdy_d  = rx_rdy_q;
    rx_hold_d = rx_hold_q;
    rbyte     = '0;
    do_read   = 1'b0;
    do_write  = 1'b0;
    result_o  = '0;

    unique case (kind_e'(item_i.kind))
      KIND_READ: begin
        priority if (item_i.access_size == SIZE_BYTE_U ||
                     item_i.access_size == SIZE_BYTE_S) begin
          do_read = 1'b1;
        end else if (item_i.access_size == SIZE_HALF ||
                     item_i.access_size == SIZE_WORD) begin
          result_o.fault = FAULT_LOAD_MIS;
        end else begin
          result_o.fault = FAULT_ILLEGAL;
        end
      end
      KIND_WRITE: begin
        priority if (item_i.access_size == SIZE_BYTE_U ||
                     item_i.access_size == SIZE_BYTE_S) begin
          do_write = 1'b1;
        end else if (item_i.access_size == SIZE_HALF ||
                     item_i.access_size == SIZE_WORD) begin
          result_o.fault = FAULT_STORE_MIS;
        end else begin
          result_o.fault = FAULT_ILLEGAL;
        end
      end
      KIND_RX: begin
        rx_hold_d = item_i.rx_byte;
        rx_rdy_d  = 1'b1;
      end
      default: ;
    endcase

    if (do_read) begin
      unique case (item_i.reg_addr)
        ADDR_RBR: begin
          if (dlab) begin
            rbyte = dll_q;
          end else if (rx_rdy_q) begin
            rbyte    = rx_hold_q;
            rx_rdy_d = 1'b0;
          end
        end
        ADDR_IER: rbyte = dlab ? dlh_q : ier_q;
        ADDR_IIR: begin
          rbyte = {6'd0, cur_q, ~|pend_q};
          // reading IIR acknowledges a THRE interrupt
          if (cur_q) pend_w[SRC_THRE] = 1'b0;
        end
        ADDR_LCR: rbyte = lcr_q;
        ADDR_MCR: rbyte = mcr_q;
        ADDR_LSR: rbyte = LSR_FIXED | {7'd0, rx_rdy_q};
        ADDR_MSR: rbyte = MSR_FIXED;
        default:  rbyte = '0;
      endcase
      result_o.read_data = (item_i.access_size == SIZE_BYTE_S)
                         ? {{24{rbyte[7]}}, rbyte} : {24'd0, rbyte};
    end

    if (do_write) begin
      unique case (item_i.reg_addr)
        ADDR_RBR: begin
          if (dlab) begin
            dll_d = item_i.write_data;
          end else begin
            result_o.tx_valid = 1'b1;
            result_o.tx_byte  = item_i.write_data;
            pend_w[SRC_THRE]  = 1'b1;
          end
        end
        ADDR_IER: begin
          if (dlab) dlh_d = item_i.write_data;
          else      ier_d = item_i.write_data;
        end
        ADDR_LCR: lcr_d = item_i.write_data;
        ADDR_MCR: mcr_d = item_i.write_data;
        default: ;
      endcase
    end

    // interrupt update: data-ready into bit 0, mask by IER, pick highest
    pend_d = {pend_w[1], rx_rdy_d} & ier_d[1:0];
    if (|pend_d) cur_d = pend_d[1];
    result_o.irq = |pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcr_q     <= '0;
      ier_q     <= '0;
      mcr_q     <= '0;
      dll_q     <= '0;
      dlh_q     <= '0;
      pend_q    <= '0;
      cur_q     <= 1'b0;
      rx_rdy_q  <= 1'b0;
      rx_hold_q <= '0;
    end else if (step_i) begin
      lcr_q     <= lcr_d;
      ier_q     <= ier_d;
      mcr_q     <= mcr_d;
      dll_q     <= dll_d;
      dlh_q     <= dlh_d;
      pend_q    <= pend_d;
      cur_q     <= cur_d;
      rx_rdy_q  <= rx_rdy_d;
      rx_hold_q <= rx_hold_d;
    end
  end

endmodule

`default_nettype wire

### src/uart_8250_register_block_unit.sv
// ----------------------------------------------------------------------------
// uart_8250_register_block_unit
// 8250-style UART register file with bus, receive and transmit events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one event per
//   beat: a bus read, a bus write or a received serial byte.
//   Output channel (out_valid_o / out_ready_i / out_data_o) returns exactly
//   one result beat per input beat, in order: read data, fault code, the
//   transmitted byte if THR was written, and the irq level after the update.
//   The register state and the result register load on the edge that accepts
//   the input beat. Throughput is one beat per cycle, set by the single result
//   register; in_ready_o is high whenever that register is empty or is being
//   drained in the same cycle.
//   When the receiver stalls, the result is held and in_ready_o drops until
//   it is taken; no events are lost.
//   Reset clears all UART registers, the interrupt state and the receive
//   holding register, and empties the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_8250_register_block_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  u8250_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output u8250_pkg::out_t  out_data_o
);
  import u8250_pkg::*;

  logic out_valid_q;
  out_t out_q;
  out_t result;
  logic in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  u8250_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (in_fire),
    .item_i   (in_data_i),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### src/u8250_checker.sv
// ----------------------------------------------------------------------------
// u8250_checker
// Port-level checks for the UART register block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module u8250_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input u8250_pkg::out_t  out_data_o
);
  import u8250_pkg::*;

  // a stalled result beat stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // every accepted event yields a result on the next cycle
  a_one_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("no result after accepted beat");

  a_tx_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.tx_valid |-> out_data_o.fault == FAULT_NONE)
    else $error("transmit on faulting access");

  a_tx_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.tx_valid |-> out_data_o.tx_byte == 8'd0)
    else $error("tx byte without tx valid");

  a_rdata_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.fault != FAULT_NONE |-> out_data_o.read_data == 32'd0)
    else $error("read data on faulting access");

endmodule

bind uart_8250_register_block_unit u8250_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

### test/tb_uart_8250_register_block_unit.sv
// ----------------------------------------------------------------------------
// tb_uart_8250_register_block_unit
// Self-checking bench for the 8250-style UART register block. A shadow copy of
// the UART registers predicts every result beat and is checked field by field
// against the output channel. The run starts with directed accesses, then
// moves to random register traffic under three idling mixes on both sides.
// ----------------------------------------------------------------------------
module tb_uart_8250_register_block_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import u8250_pkg::*;

  localparam logic [2:0] ADDR_SPARE     = 3'd7;
  localparam logic [2:0] SIZE_OTHER_LO  = 3'd4;
  localparam logic [2:0] SIZE_OTHER_HI  = 3'd7;
  localparam logic [7:0] IER_RX_AVAIL   = 8'h01;
  localparam logic [7:0] IER_THR_EMPTY  = 8'h02;
  localparam logic [7:0] LCR_DLAB       = 8'h80;
  localparam int         QUIET_LIMIT    = 2000;
  localparam int         RX_HOLD_CYCLES = 80;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_left  = 0;
  int quiet_cycles = 0;

  // Shadow of the UART registers; predicts one result per accepted beat.
  class uart_reg_shadow;
    logic [7:0] lcr, ier, mcr, dll, dlh, rx_hold;
    logic [1:0] pend;
    logic       cur_src;
    logic       rx_rdy;
    out_t       awaited[$];
    int         mismatches;

    function new();
      lcr = '0; ier = '0; mcr = '0; dll = '0; dlh = '0; rx_hold = '0;
      pend = '0; cur_src = 1'b0; rx_rdy = 1'b0;
      mismatches = 0;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    function logic [7:0] read_byte(logic [2:0] a);
      logic [7:0] v;
      v = '0;
      case (a)
        ADDR_RBR: begin
          if (lcr[DLAB_BIT]) begin
            v = dll;
          end else if (rx_rdy) begin
            v = rx_hold;
            rx_rdy = 1'b0;
          end
        end
        ADDR_IER: v = lcr[DLAB_BIT] ? dlh : ier;
        ADDR_IIR: begin
          v = {6'b0, cur_src, (pend == 2'b00)};
          // reading IIR acknowledges a THR-empty interrupt
          if (cur_src == 1'(SRC_THRE)) pend[SRC_THRE] = 1'b0;
        end
        ADDR_LCR: v = lcr;
        ADDR_MCR: v = mcr;
        ADDR_LSR: v = LSR_FIXED | {7'b0, rx_rdy};
        ADDR_MSR: v = MSR_FIXED;
        default:  v = '0;
      endcase
      return v;
    endfunction

    function void note_request(in_t it);
      out_t       r;
      logic [7:0] b;
      r = '0;
      case (it.kind)
        KIND_READ: begin
          if (it.access_size == SIZE_BYTE_U) begin
            r.read_data = {24'b0, read_byte(it.reg_addr)};
          end else if (it.access_size == SIZE_BYTE_S) begin
            b = read_byte(it.reg_addr);
            r.read_data = {{24{b[7]}}, b};
          end else if (it.access_size == SIZE_HALF || it.access_size == SIZE_WORD) begin
            r.fault = FAULT_LOAD_MIS;
          end else begin
            r.fault = FAULT_ILLEGAL;
          end
        end
        KIND_WRITE: begin
          if (it.access_size == SIZE_BYTE_U || it.access_size == SIZE_BYTE_S) begin
            case (it.reg_addr)
              ADDR_RBR: begin
                if (lcr[DLAB_BIT]) begin
                  dll = it.write_data;
                end else begin
                  r.tx_valid = 1'b1;
                  r.tx_byte = it.write_data;
                  pend[SRC_THRE] = 1'b1;
                end
              end
              ADDR_IER: begin
                if (lcr[DLAB_BIT]) dlh = it.write_data;
                else ier = it.write_data;
              end
              ADDR_LCR: lcr = it.write_data;
              ADDR_MCR: mcr = it.write_data;
              default: ;
            endcase
          end else if (it.access_size == SIZE_HALF || it.access_size == SIZE_WORD) begin
            r.fault = FAULT_STORE_MIS;
          end else begin
            r.fault = FAULT_ILLEGAL;
          end
        end
        KIND_RX: begin
          rx_hold = it.rx_byte;
          rx_rdy = 1'b1;
        end
        default: ;
      endcase
      // interrupt update after every beat
      pend[0] = rx_rdy;
      pend = pend & ier[1:0];
      if (pend != 2'b00) cur_src = pend[1];
      r.irq = (pend != 2'b00);
      awaited.push_back(r);
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_response(out_t got);
      out_t want;
      if (awaited.size() == 0) begin
        $error("result beat with no request outstanding: 0x%0h", got);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      cmp_field("read_data", want.read_data, got.read_data);
      cmp_field("fault", 32'(want.fault), 32'(got.fault));
      cmp_field("tx_valid", 32'(want.tx_valid), 32'(got.tx_valid));
      cmp_field("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
      cmp_field("irq", 32'(want.irq), 32'(got.irq));
    endfunction
  endclass

  uart_reg_shadow shadow = new();

  uart_8250_register_block_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // beat monitor: request first, so a same-edge result still finds its entry
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) shadow.note_request(in_data_i);
      if (out_valid_o && out_ready_i) shadow.check_response(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // receiver: random back-pressure, or a long hold-off when requested
  always begin
    @(negedge clk_i);
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic in_t make_event(logic [1:0] k, logic [2:0] a, logic [2:0] sz,
                                     logic [7:0] wd, logic [7:0] rb);
    in_t it;
    it.kind = k;
    it.reg_addr = a;
    it.access_size = sz;
    it.write_data = wd;
    it.rx_byte = rb;
    return it;
  endfunction

  function automatic in_t random_event();
    in_t it;
    int  pick;
    it.write_data = 8'($urandom_range(255));
    it.rx_byte = 8'($urandom_range(255));
    it.reg_addr = 3'($urandom_range(7));
    it.access_size = $urandom_range(1) ? SIZE_BYTE_S : SIZE_BYTE_U;
    pick = $urandom_range(99);
    if (pick < 34) begin
      it.kind = KIND_READ;
      // favor RBR and IIR, which have read side effects, and LSR
      case ($urandom_range(5))
        0: it.reg_addr = ADDR_RBR;
        1: it.reg_addr = ADDR_IIR;
        2: it.reg_addr = ADDR_LSR;
        default: ;
      endcase
    end else if (pick < 64) begin
      it.kind = KIND_WRITE;
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6, 7: it.reg_addr = ADDR_RBR;
        8, 9, 10, 11:           it.reg_addr = ADDR_IER;
        12, 13, 14: begin
          it.reg_addr = ADDR_LCR;
          it.write_data[DLAB_BIT] = ($urandom_range(3) == 0);
        end
        default: ;
      endcase
    end else if (pick < 82) begin
      it.kind = KIND_RX;
    end else if (pick < 94) begin
      it.kind = $urandom_range(1) ? KIND_WRITE : KIND_READ;
      case ($urandom_range(2))
        0:       it.access_size = SIZE_HALF;
        1:       it.access_size = SIZE_WORD;
        default: it.access_size = 3'($urandom_range(SIZE_OTHER_LO, SIZE_OTHER_HI));
      endcase
    end else begin
      it.kind = KIND_NOP;
      it.access_size = 3'($urandom_range(SIZE_OTHER_HI));
    end
    return it;
  endfunction

  // starts just after an edge; returns at the edge that accepts the beat
  task automatic send_beat(input in_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (shadow.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic run_random(input int count);
    in_t it;
    int  n;
    n = 0;
    while (n < count) begin
      it = random_event();
      send_beat(it);
      n++;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 32;
    rx_idle_pct = 52;

    // reset values and fixed status registers
    send_beat(make_event(KIND_READ, ADDR_IIR, SIZE_BYTE_U, 8'h00, 8'hFF));
    send_beat(make_event(KIND_READ, ADDR_LSR, SIZE_BYTE_U, 8'hFF, 8'h00));
    send_beat(make_event(KIND_READ, ADDR_MSR, SIZE_BYTE_S, 8'h00, 8'h00));
    send_beat(make_event(KIND_READ, ADDR_SPARE, SIZE_BYTE_S, 8'h00, 8'h00));
    send_beat(make_event(KIND_READ, ADDR_RBR, SIZE_BYTE_U, 8'h00, 8'h00));
    // THR-empty interrupt raised by a transmit, cleared by IIR read
    send_beat(make_event(KIND_WRITE, ADDR_IER, SIZE_BYTE_U,
                         IER_RX_AVAIL | IER_THR_EMPTY, 8'h00));
    send_beat(make_event(KIND_WRITE, ADDR_RBR, SIZE_BYTE_S, 8'hA5, 8'h00));
    send_beat(make_event(KIND_READ, ADDR_IIR, SIZE_BYTE_U, 8'h00, 8'h00));
    // second receive overwrites an unread byte
    send_beat(make_event(KIND_RX, ADDR_RBR, SIZE_BYTE_U, 8'h00, 8'h81));
    send_beat(make_event(KIND_RX, ADDR_RBR, SIZE_BYTE_U, 8'h00, 8'h7E));
    send_beat(make_event(KIND_READ, ADDR_LSR, SIZE_BYTE_U, 8'h00, 8'h00));
    send_beat(make_event(KIND_READ, ADDR_RBR, SIZE_BYTE_S, 8'h00, 8'h00));
    // divisor latch through DLAB
    send_beat(make_event(KIND_WRITE, ADDR_LCR, SIZE_BYTE_U, LCR_DLAB, 8'h00));
    send_beat(make_event(KIND_WRITE, ADDR_RBR, SIZE_BYTE_U, 8'hFF, 8'h00));
    send_beat(make_event(KIND_WRITE, ADDR_IER, SIZE_BYTE_S, 8'h81, 8'h00));
    send_beat(make_event(KIND_READ, ADDR_RBR, SIZE_BYTE_S, 8'h00, 8'h00));
    send_beat(make_event(KIND_READ, ADDR_IER, SIZE_BYTE_S, 8'h00, 8'h00));
    send_beat(make_event(KIND_WRITE, ADDR_LCR, SIZE_BYTE_U, 8'h03, 8'h00));
    send_beat(make_event(KIND_WRITE, ADDR_MCR, SIZE_BYTE_U, 8'hFF, 8'h00));
    send_beat(make_event(KIND_READ, ADDR_MCR, SIZE_BYTE_S, 8'h00, 8'h00));
    // ignored writes, faults and the no-op kind
    send_beat(make_event(KIND_WRITE, ADDR_IIR, SIZE_BYTE_U, 8'hFF, 8'h00));
    send_beat(make_event(KIND_WRITE, ADDR_SPARE, SIZE_BYTE_U, 8'hFF, 8'h00));
    send_beat(make_event(KIND_READ, ADDR_IIR, SIZE_HALF, 8'h00, 8'h00));
    send_beat(make_event(KIND_WRITE, ADDR_RBR, SIZE_WORD, 8'h55, 8'h00));
    send_beat(make_event(KIND_READ, ADDR_LSR, SIZE_OTHER_HI, 8'h00, 8'h00));
    send_beat(make_event(KIND_WRITE, ADDR_LCR, SIZE_OTHER_LO, 8'h80, 8'h00));
    send_beat(make_event(KIND_NOP, ADDR_SPARE, SIZE_OTHER_HI, 8'hFF, 8'hFF));

    run_random(300);
    stall_left = RX_HOLD_CYCLES;
    run_random(350);
    wait_drained();

    tx_idle_pct = 52;
    rx_idle_pct = 32;
    run_random(650);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(650);

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
src/u8250_pkg.sv
src/u8250_core.sv
src/uart_8250_register_block_unit.sv
src/u8250_checker.sv
test/tb_uart_8250_register_block_unit.sv
